### hw/rtl/rlenc_pkg.sv
package rlenc_pkg;

    localparam int ADDR_W      = 17;
    localparam int BYTE_W      = 8;
    localparam int MAX_WRITES  = 3;
    localparam int CNT_W       = 2;
    localparam int BLOCK_BYTES = 65536;

    localparam logic [BYTE_W-1:0] RUN_FLAG     = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_LIT_ONE  = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_RUN_ONE  = 8'h81;
    localparam logic [BYTE_W-1:0] HDR_LIT_FULL = 8'h7F;
    localparam logic [BYTE_W-1:0] HDR_RUN_FULL = 8'hFF;
    localparam logic [BYTE_W-1:0] HDR_RUN_TWO  = 8'h82;

    typedef struct packed {
        logic              first_pending;
        logic [BYTE_W-1:0] previous_byte;
        logic [ADDR_W-1:0] header_position;
        logic [BYTE_W-1:0] header_value;
        logic [ADDR_W-1:0] output_count;
        logic [ADDR_W-1:0] byte_count;
    } enc_state_t;

    localparam enc_state_t STATE_RESET = '{
        first_pending:   1'b1,
        previous_byte:   '0,
        header_position: '0,
        header_value:    '0,
        output_count:    '0,
        byte_count:      '0
    };

    typedef struct packed {
        logic [MAX_WRITES-1:0][ADDR_W-1:0] addr;
        logic [MAX_WRITES-1:0][BYTE_W-1:0] data;
        logic [CNT_W-1:0]                  count;
        logic [ADDR_W-1:0]                 length;
    } wr_bundle_t;

endpackage

### hw/rtl/rlenc_step.sv
module rlenc_step (
    input  rlenc_pkg::enc_state_t       cur,
    input  logic [rlenc_pkg::BYTE_W-1:0] data_byte,
    input  logic                        end_of_block,
    output rlenc_pkg::enc_state_t       nxt,
    output rlenc_pkg::wr_bundle_t       wr
);

    always_comb begin
        logic                            same;
        logic [rlenc_pkg::BYTE_W-1:0]    h;
        logic [rlenc_pkg::BYTE_W-1:0]    h_inc;
        logic [rlenc_pkg::ADDR_W-1:0]    oc;
        logic [rlenc_pkg::ADDR_W-1:0]    hp;
        logic                            open_lit;
        logic                            to_repeat;

        nxt       = cur;
        wr        = '0;
        same      = (data_byte == cur.previous_byte);
        h         = cur.header_value;
        h_inc     = h + 8'd1;
        oc        = cur.output_count;
        hp        = cur.header_position;
        open_lit  = 1'b0;
        to_repeat = 1'b0;

        if (cur.first_pending) begin
            nxt.first_pending = 1'b0;
            oc       = '0;
            open_lit = 1'b1;
        end else if (h == rlenc_pkg::HDR_LIT_ONE || h == rlenc_pkg::HDR_RUN_ONE) begin
            // a one-byte run turns into a repeat or a literal of two
            nxt.header_value = same ? (h_inc | rlenc_pkg::RUN_FLAG) : h_inc;
            wr.addr[0] = hp;
            wr.data[0] = nxt.header_value;
            if (same) begin
                wr.count = 2'd1;
            end else begin
                wr.addr[1] = oc;
                wr.data[1] = data_byte;
                wr.count   = 2'd2;
                nxt.output_count = oc + 17'd1;
            end
        end else if (h == rlenc_pkg::HDR_LIT_FULL && same) begin
            to_repeat = 1'b1;
        end else if (h == rlenc_pkg::HDR_LIT_FULL || h == rlenc_pkg::HDR_RUN_FULL) begin
            open_lit = 1'b1;
        end else if ((h & rlenc_pkg::RUN_FLAG) != '0) begin
            if (same) begin
                nxt.header_value = h_inc;
                wr.addr[0] = hp;
                wr.data[0] = h_inc;
                wr.count   = 2'd1;
            end else begin
                open_lit = 1'b1;
            end
        end else if (same) begin
            to_repeat = 1'b1;
        end else begin
            nxt.header_value = h_inc;
            wr.addr[0] = hp;
            wr.data[0] = h_inc;
            wr.addr[1] = oc;
            wr.data[1] = data_byte;
            wr.count   = 2'd2;
            nxt.output_count = oc + 17'd1;
        end

        if (open_lit) begin
            nxt.header_position = oc;
            nxt.header_value    = rlenc_pkg::HDR_LIT_ONE;
            wr.addr[0] = oc;
            wr.data[0] = rlenc_pkg::HDR_LIT_ONE;
            wr.addr[1] = oc + 17'd1;
            wr.data[1] = data_byte;
            wr.count   = 2'd2;
            nxt.output_count = oc + 17'd2;
        end

        if (to_repeat) begin
            // shorten the literal and reuse its last slot as a repeat header
            wr.addr[0] = hp;
            wr.data[0] = h - 8'd1;
            wr.addr[1] = oc - 17'd1;
            wr.data[1] = rlenc_pkg::HDR_RUN_TWO;
            wr.addr[2] = oc;
            wr.data[2] = data_byte;
            wr.count   = 2'd3;
            nxt.header_position = oc - 17'd1;
            nxt.header_value    = rlenc_pkg::HDR_RUN_TWO;
            nxt.output_count    = oc + 17'd1;
        end

        nxt.previous_byte = data_byte;
        nxt.byte_count    = cur.byte_count + 17'd1;
        wr.length         = nxt.output_count;

        if (end_of_block ||
            nxt.byte_count >= rlenc_pkg::ADDR_W'(rlenc_pkg::BLOCK_BYTES)) begin
            nxt = rlenc_pkg::STATE_RESET;
        end
    end

endmodule

### hw/rtl/rle_literal_run_byte_encoder.sv
// An input beat is registered in the bundle stage and then loaded into the output stage,
// from which its write beats are presented on the result port.
// Throughput: one write beat per cycle while m_ready is high; a byte has 1 to 3 writes,
// issued one at a time through the single-beat result port. The input stalls only while both stages hold.
// Reset (aresetn low, synchronous): encoder state returns to start of block,
// buffered and pending write beats are dropped.
module rle_literal_run_byte_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rlenc_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic                          s_end_of_block,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rlenc_pkg::ADDR_W-1:0]  m_write_address,
    output logic [rlenc_pkg::BYTE_W-1:0]  m_write_byte,
    output logic                          m_last_write,
    output logic [rlenc_pkg::ADDR_W-1:0]  m_encoded_length
);

    rlenc_pkg::enc_state_t state_reg;
    rlenc_pkg::enc_state_t state_next;
    rlenc_pkg::wr_bundle_t step_wr;
    rlenc_pkg::wr_bundle_t bundle_reg;
    rlenc_pkg::wr_bundle_t drain_reg;
    logic                  bundle_valid_reg;
    logic                  drain_valid_reg;
    logic [rlenc_pkg::CNT_W-1:0] idx_reg;

    logic in_fire;
    logic out_fire;
    logic out_last;
    logic drain_load;

    rlenc_step u_step (
        .cur          (state_reg),
        .data_byte    (s_data_byte),
        .end_of_block (s_end_of_block),
        .nxt          (state_next),
        .wr           (step_wr)
    );

    // accept while the bundle stage is empty or moving into the output stage
    assign s_ready    = !bundle_valid_reg || drain_load;
    assign in_fire    = s_valid && s_ready;
    assign m_valid    = drain_valid_reg;
    assign out_last   = (idx_reg == drain_reg.count - 2'd1);
    assign out_fire   = m_valid && m_ready;
    assign drain_load = bundle_valid_reg && (!drain_valid_reg || (out_fire && out_last));

    assign m_write_address  = drain_reg.addr[idx_reg];
    assign m_write_byte     = drain_reg.data[idx_reg];
    assign m_last_write     = out_last;
    assign m_encoded_length = drain_reg.length;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= rlenc_pkg::STATE_RESET;
            bundle_valid_reg <= 1'b0;
            drain_valid_reg  <= 1'b0;
            idx_reg          <= '0;
        end else begin
            if (in_fire) begin
                state_reg <= state_next;
            end
            if (in_fire) begin
                bundle_valid_reg <= 1'b1;
            end else if (drain_load) begin
                bundle_valid_reg <= 1'b0;
            end
            if (drain_load) begin
                drain_valid_reg <= 1'b1;
                idx_reg         <= '0;
            end else if (out_fire) begin
                // advance through the writes; drop the bundle after its last beat
                if (out_last) begin
                    drain_valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            bundle_reg <= step_wr;
        end
        if (drain_load) begin
            drain_reg <= bundle_reg;
        end
    end

endmodule
